/* src/kme_pkg.sv */
// Shared constants and codes for the keystream and tag envelope core.
`timescale 1ns / 1ps
package kme_pkg;

	localparam int KEY_BYTES_DEF   = 64;
	localparam int MAX_MESSAGE_DEF = 4096;
	localparam int NONCE_LEN       = 12;
	localparam int TAG_LEN         = 16;

	localparam logic [2:0] ACT_KEY    = 3'd0;
	localparam logic [2:0] ACT_NONCE  = 3'd1;
	localparam logic [2:0] ACT_TAG    = 3'd2;
	localparam logic [2:0] ACT_SEAL   = 3'd3;
	localparam logic [2:0] ACT_OPEN   = 3'd4;
	localparam logic [2:0] ACT_DATA   = 3'd5;
	localparam logic [2:0] ACT_FINISH = 3'd6;

	localparam logic [1:0] KIND_NONCE   = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_TAG     = 2'd2;
	localparam logic [1:0] KIND_VERDICT = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_LIMIT    = 2'd1;
	localparam logic [1:0] ST_NO_RUN   = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_SEAL = 2'd1;
	localparam logic [1:0] MODE_OPEN = 2'd2;

	localparam logic [31:0] LANE_SEED  = 32'h9e3779b9;
	localparam logic [31:0] MIX_PRIME  = 32'd16777619;
	localparam logic [7:0]  KS_STEP    = 8'd31;
	localparam logic [7:0]  KS_INIT    = 8'd7;
	localparam logic [7:0]  NONCE_STEP = 8'd101;
	localparam int          XS_SHIFT   = 13;
	localparam logic [7:0]  KEY_RESET  = 8'h5a;

endpackage

/* src/keystream_mac_envelope_core.sv */
// Top level of the keystream and tag envelope core.
`timescale 1ns / 1ps
// The block takes one input beat at a time and returns to accept the next
// once all its results have entered the output register. Store writes keep
// it idle. A data byte passes the accepting state, then read of key and
// tag lane, keystream and sum, constant multiply, write-back of the lane.
// Begin seal reads and emits each nonce byte, then reads and writes each of
// the sixteen tag lanes to seed them; begin open only seeds the lanes,
// finish of a seal reads and emits each tag byte and finish of an open
// compares each lane before its verdict, all set by the single read port
// of the key and lane memories. There is no clearing pass after reset.
module keystream_mac_envelope_core
	import kme_pkg::*;
#(
	parameter int KEY_BYTES   = KEY_BYTES_DEF,
	parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // index [5:0], value [13:6], zero [15:14]
	input  logic [2:0]  s_tuser,   // action [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte [7:0]
	output logic [3:0]  m_tuser,   // kind [1:0], status [3:2]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	localparam int KA_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int KL_W = $clog2(KEY_BYTES + 1);
	localparam int CW   = (KL_W > 7) ? KL_W : 7;
	localparam int IW   = (KA_W > 6) ? KA_W : 6;
	localparam int PW   = $clog2(MAX_MESSAGE + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ONE  = 4'd1;
	localparam logic [3:0] S_NRD  = 4'd2;
	localparam logic [3:0] S_NEM  = 4'd3;
	localparam logic [3:0] S_LRD  = 4'd4;
	localparam logic [3:0] S_LWR  = 4'd5;
	localparam logic [3:0] S_DRD  = 4'd6;
	localparam logic [3:0] S_DEM  = 4'd7;
	localparam logic [3:0] S_DMUL = 4'd8;
	localparam logic [3:0] S_DWR  = 4'd9;
	localparam logic [3:0] S_FRD  = 4'd10;
	localparam logic [3:0] S_FEM  = 4'd11;
	localparam logic [3:0] S_VRD  = 4'd12;
	localparam logic [3:0] S_VACC = 4'd13;
	localparam logic [3:0] S_VEM  = 4'd14;

	function automatic logic [KA_W-1:0] wrap_inc(input logic [KA_W-1:0] x,
			input logic [KL_W-1:0] lim);
		logic [KL_W-1:0] nx;
		nx = KL_W'(x) + KL_W'(1);
		return (nx >= lim) ? '0 : KA_W'(nx);
	endfunction

	logic [3:0]      state_q;
	logic [6:0]      key_length_q;
	logic [1:0]      mode_q;
	logic [1:0]      mode_nx_q;
	logic [31:0]     msg_ctr_q;
	logic [PW-1:0]   pos_q;
	logic [3:0]      pos12_q;
	logic [3:0]      pos16_q;
	logic [7:0]      ks_add_q;
	logic [KA_W-1:0] cursor_q;
	logic [KA_W-1:0] kidx_q;
	logic [3:0]      i_q;
	logic [7:0]      step101_q;
	logic [7:0]      val_q;
	logic            diff_q;
	logic [1:0]      one_kind_q;
	logic [1:0]      one_st_q;
	logic [7:0]      nonce_q [NONCE_LEN];
	logic [31:0]     sum_s1;
	logic [31:0]     prod_s2;

	logic            ovalid_q;
	logic [7:0]      obyte_q;
	logic [1:0]      okind_q;
	logic [1:0]      ost_q;
	logic            olast_q;

	logic [31:0] lane_mem [TAG_LEN];
	logic [31:0] lane_rd_q;
	logic [7:0]  exp_mem [TAG_LEN];
	logic [7:0]  exp_rd_q;

	logic [2:0]      action;
	logic [5:0]      idx;
	logic [7:0]      value;
	logic            accept;
	logic            out_free;
	logic            emit;
	logic [CW-1:0]   len_wide;
	logic [KL_W-1:0] kl;
	logic [KA_W-1:0] cur_eff;
	logic [KA_W-1:0] key_raddr;
	logic [IW-1:0]   idx_wide;
	logic            key_we;
	logic [7:0]      key_rd;
	logic            data_st;
	logic [3:0]      nidx;
	logic [7:0]      nonce_rd;
	logic [3:0]      lane_raddr;
	logic [7:0]      ks;
	logic [7:0]      res;
	logic [7:0]      ct;
	logic [7:0]      fold;
	logic [7:0]      nonce_new;
	logic [31:0]     lane_seed_val;
	logic [31:0]     lane_mix;

	assign action   = s_tuser;
	assign idx      = s_tdata[5:0];
	assign value    = s_tdata[13:6];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !ovalid_q || m_tready;
	assign emit     = out_free && (state_q inside {S_ONE, S_NEM, S_DEM, S_FEM, S_VEM});

	always_comb begin
		len_wide = CW'(key_length_q);
		if (len_wide == '0) begin
			kl = KL_W'(1);
		end else if (len_wide > CW'(KEY_BYTES)) begin
			kl = KL_W'(KEY_BYTES);
		end else begin
			kl = KL_W'(len_wide);
		end
	end

	assign cur_eff   = (KL_W'(cursor_q) >= kl) ? '0 : cursor_q;
	assign data_st   = (state_q == S_DRD) || (state_q == S_DEM);
	assign key_raddr = data_st ? cur_eff : kidx_q;
	assign idx_wide  = IW'(idx);
	assign key_we    = accept && (action == ACT_KEY) && (32'(idx) < 32'(KEY_BYTES));

	kme_key_store #(
		.KEY_BYTES(KEY_BYTES),
		.KA_W     (KA_W)
	) u_key (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (key_we),
		.waddr (idx_wide[KA_W-1:0]),
		.wdata (value),
		.raddr (key_raddr),
		.rdata (key_rd)
	);

	assign nidx       = data_st ? pos12_q : ((i_q < 4'(NONCE_LEN)) ? i_q : i_q - 4'(NONCE_LEN));
	assign nonce_rd   = nonce_q[nidx];
	assign lane_raddr = data_st ? pos16_q : i_q;

	assign ks        = (key_rd ^ nonce_rd) + ks_add_q;
	assign res       = val_q ^ ks;
	assign ct        = (mode_q == MODE_SEAL) ? res : val_q;
	assign fold      = lane_rd_q[7:0] ^ lane_rd_q[15:8] ^ lane_rd_q[23:16];
	assign nonce_new = msg_ctr_q[8*i_q[1:0] +: 8] ^ (key_rd + step101_q);
	assign lane_seed_val = LANE_SEED ^ {24'd0, key_rd} ^ {24'd0, nonce_rd};
	assign lane_mix  = prod_s2 ^ (prod_s2 >> XS_SHIFT);

	// Lane and expected-tag memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (state_q == S_LWR) begin
			lane_mem[i_q] <= lane_seed_val;
		end else if (state_q == S_DWR) begin
			lane_mem[pos16_q] <= lane_mix;
		end
		lane_rd_q <= lane_mem[lane_raddr];
		if (accept && (action == ACT_TAG) && (idx < 6'(TAG_LEN))) begin
			exp_mem[idx[3:0]] <= value;
		end
		exp_rd_q <= exp_mem[i_q];
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
		end
		sum_s1  <= lane_rd_q + {24'd0, ct} + 32'd1;
		prod_s2 <= sum_s1 * MIX_PRIME;
		if (out_free) begin
			case (state_q)
				S_ONE: begin
					obyte_q <= 8'd0;
					okind_q <= one_kind_q;
					ost_q   <= one_st_q;
					olast_q <= 1'b1;
				end
				S_NEM: begin
					obyte_q <= nonce_new;
					okind_q <= KIND_NONCE;
					ost_q   <= ST_OK;
					olast_q <= (i_q == 4'(NONCE_LEN - 1));
				end
				S_DEM: begin
					obyte_q <= res;
					okind_q <= KIND_DATA;
					ost_q   <= ST_OK;
					olast_q <= 1'b1;
				end
				S_FEM: begin
					obyte_q <= fold;
					okind_q <= KIND_TAG;
					ost_q   <= ST_OK;
					olast_q <= (i_q == 4'(TAG_LEN - 1));
				end
				S_VEM: begin
					obyte_q <= 8'd0;
					okind_q <= KIND_VERDICT;
					ost_q   <= diff_q ? ST_MISMATCH : ST_OK;
					olast_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			key_length_q <= 7'd1;
			mode_q       <= MODE_IDLE;
			mode_nx_q    <= MODE_IDLE;
			msg_ctr_q    <= '0;
			pos_q        <= '0;
			pos12_q      <= '0;
			pos16_q      <= '0;
			ks_add_q     <= KS_INIT;
			cursor_q     <= '0;
			kidx_q       <= '0;
			i_q          <= '0;
			step101_q    <= '0;
			diff_q       <= 1'b0;
			one_kind_q   <= KIND_DATA;
			one_st_q     <= ST_OK;
			ovalid_q     <= 1'b0;
			for (int n = 0; n < NONCE_LEN; n++) begin
				nonce_q[n] <= 8'd0;
			end
		end else begin
			if (cfg_we) begin
				key_length_q <= cfg_wdata;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_NONCE: begin
								if (idx < 6'(NONCE_LEN)) begin
									nonce_q[idx[3:0]] <= value;
								end
							end
							ACT_SEAL: begin
								msg_ctr_q <= msg_ctr_q + 32'd1;
								kidx_q    <= '0;
								i_q       <= '0;
								step101_q <= 8'd0;
								state_q   <= S_NRD;
							end
							ACT_OPEN: begin
								kidx_q    <= '0;
								i_q       <= '0;
								mode_nx_q <= MODE_OPEN;
								state_q   <= S_LRD;
							end
							ACT_DATA: begin
								if (mode_q == MODE_IDLE) begin
									one_kind_q <= KIND_DATA;
									one_st_q   <= ST_NO_RUN;
									state_q    <= S_ONE;
								end else if (pos_q == PW'(MAX_MESSAGE)) begin
									one_kind_q <= KIND_DATA;
									one_st_q   <= ST_LIMIT;
									state_q    <= S_ONE;
								end else begin
									state_q <= S_DRD;
								end
							end
							ACT_FINISH: begin
								i_q    <= '0;
								diff_q <= 1'b0;
								if (mode_q == MODE_IDLE) begin
									one_kind_q <= KIND_VERDICT;
									one_st_q   <= ST_NO_RUN;
									state_q    <= S_ONE;
								end else if (mode_q == MODE_SEAL) begin
									state_q <= S_FRD;
								end else begin
									state_q <= S_VRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_NRD: begin
					state_q <= S_NEM;
				end
				S_NEM: begin
					if (out_free) begin
						nonce_q[i_q]   <= nonce_new;
						step101_q      <= step101_q + NONCE_STEP;
						if (i_q == 4'(NONCE_LEN - 1)) begin
							i_q       <= '0;
							kidx_q    <= '0;
							mode_nx_q <= MODE_SEAL;
							state_q   <= S_LRD;
						end else begin
							i_q     <= i_q + 4'd1;
							kidx_q  <= wrap_inc(kidx_q, kl);
							state_q <= S_NRD;
						end
					end
				end
				S_LRD: begin
					state_q <= S_LWR;
				end
				S_LWR: begin
					// Lane seeding ends the start of a run.
					if (i_q == 4'(TAG_LEN - 1)) begin
						mode_q   <= mode_nx_q;
						pos_q    <= '0;
						pos12_q  <= '0;
						pos16_q  <= '0;
						ks_add_q <= KS_INIT;
						cursor_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						i_q     <= i_q + 4'd1;
						kidx_q  <= wrap_inc(kidx_q, kl);
						state_q <= S_LRD;
					end
				end
				S_DRD: begin
					cursor_q <= cur_eff;
					state_q  <= S_DEM;
				end
				S_DEM: begin
					if (out_free) begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: begin
					state_q <= S_DWR;
				end
				S_DWR: begin
					pos_q    <= pos_q + PW'(1);
					pos12_q  <= (pos12_q == 4'(NONCE_LEN - 1)) ? 4'd0 : pos12_q + 4'd1;
					pos16_q  <= pos16_q + 4'd1;
					ks_add_q <= ks_add_q + KS_STEP;
					cursor_q <= wrap_inc(cursor_q, kl);
					state_q  <= S_IDLE;
				end
				S_FRD: begin
					state_q <= S_FEM;
				end
				S_FEM: begin
					if (out_free) begin
						if (i_q == 4'(TAG_LEN - 1)) begin
							mode_q  <= MODE_IDLE;
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 4'd1;
							state_q <= S_FRD;
						end
					end
				end
				S_VRD: begin
					state_q <= S_VACC;
				end
				S_VACC: begin
					diff_q <= diff_q | (fold != exp_rd_q);
					if (i_q == 4'(TAG_LEN - 1)) begin
						state_q <= S_VEM;
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= S_VRD;
					end
				end
				S_VEM: begin
					if (out_free) begin
						mode_q  <= MODE_IDLE;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = obyte_q;
	assign m_tuser  = {ost_q, okind_q};
	assign m_tlast  = olast_q;

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_MESSAGE))
		else $error("byte position beyond message limit");
	a_pos12_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos12_q < 4'(NONCE_LEN))
		else $error("nonce position out of range");
	a_lane_track: assert property (@(posedge clk) disable iff (!arst_n)
		pos16_q == 4'(pos_q))
		else $error("lane index out of step with byte position");
	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DMUL |=> state_q == S_DWR)
		else $error("multiply stage not followed by lane write-back");
`endif

endmodule

/* src/kme_key_store.sv */
// Key byte memory with per-entry valid bits that supply the reset contents.
`timescale 1ns / 1ps
module kme_key_store
	import kme_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF,
	parameter int KA_W      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  logic [KA_W-1:0] waddr,
	input  logic [7:0]      wdata,
	input  logic [KA_W-1:0] raddr,
	output logic [7:0]      rdata
);

	logic [7:0]     mem [KEY_BYTES];
	logic [KEY_BYTES-1:0] valid_q;
	logic [7:0]     rd_q;
	logic           rd_valid_q;
	logic           rd_zero_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_zero_q  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[raddr];
			rd_zero_q  <= (raddr == '0);
		end
	end

	// An entry never written reads as its reset value.
	assign rdata = rd_valid_q ? rd_q : (rd_zero_q ? KEY_RESET : 8'd0);

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the keystream and tag envelope core.
`timescale 1ns / 1ps
module tb_top;
	import kme_pkg::*;

	localparam int KEY_DEPTH   = 64;
	localparam int MSG_LIMIT   = 4096;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] index;
		logic [7:0] value;
	} beat_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last;
		logic [1:0] status;
	} beat_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;

	keystream_mac_envelope_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Shadow state of the envelope core.
	logic [7:0]  key_mem [KEY_DEPTH];
	logic [7:0]  nonce_mem [NONCE_LEN];
	logic [31:0] lane_acc [TAG_LEN];
	logic [7:0]  tag_expect [TAG_LEN];
	logic [31:0] msg_count;
	int          msg_pos;
	int          key_pos;
	logic [1:0]  run_state;
	logic [6:0]  key_len_reg;
	logic [7:0]  last_data_out;
	logic [7:0]  sealed_tag [TAG_LEN];

	beat_in_t    send_queue[$];
	beat_out_t   result_queue[$];
	bit          no_gaps = 1'b0;
	int          mismatches = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          queued = 0;
	int          seal_runs = 0;
	int          open_runs = 0;
	int          idle_cycles = 0;

	function automatic int eff_key_len();
		int k;
		k = key_len_reg;
		if (k == 0) k = 1;
		if (k > KEY_DEPTH) k = KEY_DEPTH;
		return k;
	endfunction

	function automatic void push_result(logic [7:0] b, logic [1:0] kind, logic last,
			logic [1:0] st);
		beat_out_t r;
		r.out_byte = b;
		r.kind = kind;
		r.last = last;
		r.status = st;
		result_queue.push_back(r);
	endfunction

	function automatic void seed_lanes(logic [1:0] mode);
		int kl;
		kl = eff_key_len();
		for (int i = 0; i < TAG_LEN; i++)
			lane_acc[i] = LANE_SEED ^ {24'd0, key_mem[i % kl]}
				^ {24'd0, nonce_mem[i % NONCE_LEN]};
		msg_pos = 0;
		key_pos = 0;
		run_state = mode;
	endfunction

	function automatic logic [7:0] fold_lane(logic [31:0] a);
		logic [31:0] f;
		f = a ^ (a >> 8) ^ (a >> 16);
		return f[7:0];
	endfunction

	// Advances the shadow state by one input beat and queues its results.
	function automatic void envelope_step(beat_in_t it);
		int          kl;
		logic [31:0] c, s, sum;
		logic [7:0]  ks, res, ct, diff;
		kl = eff_key_len();
		case (it.action)
			ACT_KEY: key_mem[it.index] = it.value;
			ACT_NONCE: if (it.index < NONCE_LEN) nonce_mem[it.index] = it.value;
			ACT_TAG: if (it.index < TAG_LEN) tag_expect[it.index] = it.value;
			ACT_SEAL: begin
				msg_count = msg_count + 1;
				for (int i = 0; i < NONCE_LEN; i++) begin
					c = msg_count >> ((i % 4) * 8);
					sum = {24'd0, key_mem[i % kl]} + i * NONCE_STEP;
					nonce_mem[i] = c[7:0] ^ sum[7:0];
					push_result(nonce_mem[i], KIND_NONCE, i == NONCE_LEN - 1, ST_OK);
				end
				seed_lanes(MODE_SEAL);
			end
			ACT_OPEN: seed_lanes(MODE_OPEN);
			ACT_DATA: begin
				if (run_state == MODE_IDLE) begin
					push_result(8'd0, KIND_DATA, 1'b1, ST_NO_RUN);
				end else if (msg_pos >= MSG_LIMIT) begin
					push_result(8'd0, KIND_DATA, 1'b1, ST_LIMIT);
				end else begin
					if (key_pos >= kl) key_pos = 0;
					sum = msg_pos * KS_STEP + KS_INIT;
					ks = (key_mem[key_pos] ^ nonce_mem[msg_pos % NONCE_LEN]) + sum[7:0];
					res = it.value ^ ks;
					ct = (run_state == MODE_SEAL) ? res : it.value;
					s = (lane_acc[msg_pos % TAG_LEN] + ct + 1) * MIX_PRIME;
					s = s ^ (s >> XS_SHIFT);
					lane_acc[msg_pos % TAG_LEN] = s;
					msg_pos++;
					key_pos = (key_pos + 1 >= kl) ? 0 : key_pos + 1;
					last_data_out = res;
					push_result(res, KIND_DATA, 1'b1, ST_OK);
				end
			end
			ACT_FINISH: begin
				if (run_state == MODE_IDLE) begin
					push_result(8'd0, KIND_VERDICT, 1'b1, ST_NO_RUN);
				end else if (run_state == MODE_SEAL) begin
					for (int i = 0; i < TAG_LEN; i++) begin
						sealed_tag[i] = fold_lane(lane_acc[i]);
						push_result(sealed_tag[i], KIND_TAG, i == TAG_LEN - 1, ST_OK);
					end
					run_state = MODE_IDLE;
				end else begin
					diff = 8'd0;
					for (int i = 0; i < TAG_LEN; i++)
						diff = diff | (fold_lane(lane_acc[i]) ^ tag_expect[i]);
					run_state = MODE_IDLE;
					push_result(8'd0, KIND_VERDICT, 1'b1, diff == 8'd0 ? ST_OK : ST_MISMATCH);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic queue_beat(logic [2:0] action, logic [5:0] index, logic [7:0] value);
		beat_in_t it;
		it.action = action;
		it.index = index;
		it.value = value;
		if (action == ACT_SEAL) seal_runs++;
		if (action == ACT_OPEN) open_runs++;
		queued++;
		envelope_step(it);
		send_queue.push_back(it);
	endtask

	task automatic drain();
		while (send_queue.size() != 0 || s_tvalid || result_queue.size() != 0)
			@(posedge clk);
	endtask

	// Register writes happen only with the core idle; begin open leaves no
	// result behind, so allow its full latency to pass first.
	task automatic write_key_length(logic [6:0] v);
		drain();
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_len_reg = v;
	endtask

	// Seals a random message, then opens it again with the matching tag,
	// sometimes with one tag byte flipped.
	task automatic seal_then_open(int len, bit corrupt);
		logic [7:0] ct [$];
		int         bad;
		ct.delete();
		queue_beat(ACT_SEAL, 6'($urandom), 8'($urandom));
		for (int j = 0; j < len; j++) begin
			queue_beat(ACT_DATA, 6'($urandom), 8'($urandom));
			ct.push_back(last_data_out);
		end
		queue_beat(ACT_FINISH, 6'($urandom), 8'($urandom));
		bad = corrupt ? $urandom_range(0, TAG_LEN - 1) : -1;
		for (int i = 0; i < TAG_LEN; i++)
			queue_beat(ACT_TAG, 6'(i),
				sealed_tag[i] ^ ((i == bad) ? 8'($urandom_range(1, 255)) : 8'd0));
		queue_beat(ACT_OPEN, 6'($urandom), 8'($urandom));
		foreach (ct[j]) queue_beat(ACT_DATA, 6'($urandom), ct[j]);
		queue_beat(ACT_FINISH, 6'($urandom), 8'($urandom));
	endtask

	task automatic random_noise();
		logic [2:0] a;
		a = 3'($urandom_range(0, 7));
		// Expected-tag writes stay in range so that no entry is left unset.
		if (a == ACT_TAG)
			queue_beat(a, 6'($urandom_range(0, TAG_LEN - 1)), 8'($urandom));
		else
			queue_beat(a, 6'($urandom), 8'($urandom));
	endtask

	always @(posedge clk) begin : driver
		logic nv;
		int   gap;
		beat_in_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap = 0;
		end else begin
			nv = s_tvalid;
			if (s_tvalid && s_tready) begin
				nv = 1'b0;
				beats_in++;
			end
			if (!nv) begin
				if (gap > 0) begin
					gap--;
				end else if (send_queue.size() != 0) begin
					it = send_queue.pop_front();
					s_tdata <= {2'b00, it.value, it.index};
					s_tuser <= it.action;
					nv = 1'b1;
					gap = no_gaps ? 0 : $urandom_range(0, 16);
				end
			end
			s_tvalid <= nv;
		end
	end

	always @(posedge clk) begin : monitor
		int        stall;
		beat_out_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_out++;
				got.out_byte = m_tdata;
				got.kind = m_tuser[1:0];
				got.status = m_tuser[3:2];
				got.last = m_tlast;
				if (result_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: byte %h kind %0d status %0d last %0d",
							got.out_byte, got.kind, got.status, got.last);
				end else begin
					want = result_queue.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected byte %h kind %0d status %0d last %0d,",
								beats_out, want.out_byte, want.kind, want.status, want.last,
								" got byte %h kind %0d status %0d last %0d",
								got.out_byte, got.kind, got.status, got.last);
					end
				end
				stall = no_gaps ? 0 : $urandom_range(0, 16);
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		foreach (key_mem[i]) key_mem[i] = 8'd0;
		key_mem[0] = KEY_RESET;
		foreach (nonce_mem[i]) nonce_mem[i] = 8'd0;
		foreach (lane_acc[i]) lane_acc[i] = 32'd0;
		foreach (tag_expect[i]) tag_expect[i] = 8'd0;
		msg_count = 32'd0;
		msg_pos = 0;
		key_pos = 0;
		run_state = MODE_IDLE;
		key_len_reg = 7'd1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle misuse, out-of-range stores, reset key, extreme bytes.
		for (int i = 0; i < TAG_LEN; i++) queue_beat(ACT_TAG, 6'(i), 8'hff);
		queue_beat(ACT_DATA, 6'd0, 8'hff);
		queue_beat(ACT_FINISH, 6'd63, 8'h00);
		queue_beat(3'd7, 6'd63, 8'hff);
		queue_beat(ACT_TAG, 6'd63, 8'h00);
		queue_beat(ACT_NONCE, 6'd12, 8'hff);
		queue_beat(ACT_SEAL, 6'd0, 8'd0);
		queue_beat(ACT_DATA, 6'd0, 8'h00);
		queue_beat(ACT_DATA, 6'd63, 8'hff);
		queue_beat(ACT_OPEN, 6'd0, 8'd0);
		queue_beat(ACT_DATA, 6'd0, 8'h80);
		queue_beat(ACT_FINISH, 6'd0, 8'd0);
		seal_then_open(3, 1'b0);

		write_key_length(7'd64);
		queue_beat(ACT_KEY, 6'd63, 8'hff);
		for (int i = 0; i < 8; i++) queue_beat(ACT_KEY, 6'($urandom), 8'($urandom));
		seal_then_open(5, 1'b0);

		write_key_length(7'd0);
		seal_then_open(2, 1'b1);

		write_key_length(7'd127);
		no_gaps = 1'b1;
		seal_then_open(4, 1'b0);
		drain();
		no_gaps = 1'b0;

		// Random part: short well-formed runs, with noise between them.
		write_key_length(7'($urandom_range(1, 127)));
		while (queued < 150) begin
			if ($urandom_range(0, 2) == 0)
				random_noise();
			else
				seal_then_open($urandom_range(0, 3), $urandom_range(0, 3) == 0);
		end
		drain();
		repeat (100) @(posedge clk);

		$display("%0d input beats and %0d result beats, %0d seal and %0d open runs,",
			beats_in, beats_out, seal_runs, open_runs);
		$display("several key lengths, corrupted tags and misuse of an idle core");
		if (mismatches == 0 && result_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
src/kme_pkg.sv
src/kme_key_store.sv
src/keystream_mac_envelope_core.sv
tb/sv/tb_top.sv
